// ----- sv/mstk_pkg.sv -----
// Package for the Kruskal spanning tree block: sizes, widths, command and status structs.
// Used by mstk_ctrl, mstk_datapath and the top level.
package mstk_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 256;
  localparam int WeightBits  = 16;
  localparam int VBits       = $clog2(MaxVertices);
  localparam int EBits       = $clog2(MaxEdges);
  localparam int CntBits     = EBits + 1;
  localparam int VcBits      = 7;
  localparam int EdgeBits    = 2 * VBits + WeightBits;

  typedef struct packed {
    logic [VBits-1:0]      src;
    logic [VBits-1:0]      dst;
    logic [WeightBits-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic store_edge;
    logic run_clear;
    logic sort_start;
    logic sort_step;
    logic sort_write;
    logic par_init;
    logic walk_start;
    logic walk_read;
    logic find_src;
    logic read_dst;
    logic find_dst;
    logic link;
    logic emit_edge;
    logic emit_empty;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sort_done;
    logic sort_shift;
    logic par_done;
    logic walk_done;
    logic skip_edge;
    logic src_at_root;
    logic dst_at_root;
    logic roots_differ;
    logic have_accept;
  } sts_t;
endpackage

// ----- sv/mstk_datapath.sv -----
// Datapath of the Kruskal block: edge memory, insertion sort, parent memory,
// root search and result register. Depends on mstk_pkg.
module mstk_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mstk_pkg::cmd_t                cmd,
  output mstk_pkg::sts_t                sts,
  input  mstk_pkg::edge_t               in_edge,
  input  logic [mstk_pkg::VcBits-1:0]   vertex_count,
  output mstk_pkg::edge_t               res_edge,
  output logic                          res_valid,
  output logic                          res_complete,
  output logic                          res_dropped
);
  localparam int VB = mstk_pkg::VBits;
  localparam int CB = mstk_pkg::CntBits;
  localparam int EB = mstk_pkg::EBits;

  mstk_pkg::edge_t store [mstk_pkg::MaxEdges];
  logic [VB-1:0]   parent [mstk_pkg::MaxVertices];

  logic [CB-1:0] count;
  logic          overflow;
  logic [CB-1:0] si, sj;
  mstk_pkg::edge_t key, rd_edge;
  logic [CB-1:0] wi;
  mstk_pkg::edge_t cur;
  mstk_pkg::edge_t held;
  logic [VB-1:0] vs, vd, par_rd;
  logic [VB:0]   pinit;
  logic [VB-1:0] accepted;
  logic [VB:0]   nact;
  logic [CB-1:0] rd_addr;
  logic          rd_phase;

  always_comb begin
    if (vertex_count == '0) nact = (VB+1)'(1);
    else if (vertex_count > mstk_pkg::VcBits'(mstk_pkg::MaxVertices))
      nact = (VB+1)'(mstk_pkg::MaxVertices);
    else nact = (VB+1)'(vertex_count);
  end

  // sort: si = key index, sj = insertion slot; rd_edge holds store[sj-1]
  always_comb begin
    if (cmd.walk_read) rd_addr = wi;
    else if (cmd.sort_start) rd_addr = si;
    else rd_addr = sj - CB'(1);
  end

  always_ff @(posedge clk) begin
    rd_edge <= store[rd_addr[EB-1:0]];
    if (cmd.store_edge && count < CB'(mstk_pkg::MaxEdges))
      store[count[EB-1:0]] <= in_edge;
    else if (cmd.sort_write) begin
      if (sts.sort_shift) store[sj[EB-1:0]] <= rd_edge;
      else store[sj[EB-1:0]] <= key;
    end
  end

  assign sts.sort_shift = (sj != '0) && rd_phase && (rd_edge.weight > key.weight);
  assign sts.sort_done  = (si >= count);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; overflow <= 1'b0; si <= CB'(1); sj <= '0; rd_phase <= 1'b0;
    end else begin
      if (cmd.store_edge) begin
        if (count < CB'(mstk_pkg::MaxEdges)) count <= count + CB'(1);
        else overflow <= 1'b1;
      end
      if (cmd.run_clear) begin
        count <= '0; overflow <= 1'b0; si <= CB'(1);
      end
      if (cmd.sort_start) begin
        sj <= si; rd_phase <= 1'b0;
      end else if (cmd.sort_step) begin
        rd_phase <= 1'b1;
      end else if (cmd.sort_write) begin
        rd_phase <= 1'b0;
        if (sts.sort_shift) sj <= sj - CB'(1);
        else si <= si + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_step && !rd_phase && sj == si) key <= rd_edge;
  end

  // parent memory
  always_ff @(posedge clk) begin
    if (cmd.par_init) parent[pinit[VB-1:0]] <= pinit[VB-1:0];
    else if (cmd.link) parent[vs] <= vd;
    par_rd <= parent[cmd.read_dst ? vd : vs];
  end
  assign sts.par_done = (pinit == (VB+1)'(mstk_pkg::MaxVertices - 1));

  assign sts.walk_done = (wi >= count) || ({1'b0, accepted} == nact - (VB+1)'(1));
  assign sts.skip_edge = ((VB+1)'(cur.src) >= nact) || ((VB+1)'(cur.dst) >= nact);
  assign sts.src_at_root = (par_rd == vs);
  assign sts.dst_at_root = (par_rd == vd);
  assign sts.roots_differ = (vs != vd);
  assign sts.have_accept = (accepted != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pinit <= '0; wi <= '0; accepted <= '0;
    end else begin
      if (cmd.par_init) pinit <= pinit + (VB+1)'(1);
      if (cmd.walk_start) begin
        pinit <= '0; wi <= '0; accepted <= '0;
      end
      if (cmd.walk_read) wi <= wi + CB'(1);
      if (cmd.emit_edge) accepted <= accepted + VB'(1);
    end
  end

  // vs/vd walk toward roots; loaded from the edge read
  logic loaded;
  always_ff @(posedge clk) begin
    if (rst) loaded <= 1'b0;
    else loaded <= cmd.walk_read;
    if (loaded) begin
      cur <= rd_edge; vs <= rd_edge.src; vd <= rd_edge.dst;
    end else if (cmd.find_src && !sts.src_at_root) vs <= par_rd;
    else if (cmd.find_dst && !sts.dst_at_root) vd <= par_rd;
  end

  // hold each accepted edge until the next accept or the walk end sets its last flag
  always_ff @(posedge clk) begin
    if (cmd.emit_edge) held <= cur;
    if (cmd.finish || (cmd.emit_edge && sts.have_accept)) begin
      res_edge     <= cmd.emit_empty ? '0 : held;
      res_valid    <= !cmd.emit_empty;
      res_complete <= cmd.finish && ({1'b0, accepted} == nact - (VB+1)'(1));
      res_dropped  <= cmd.finish && overflow;
    end
  end
endmodule

// ----- sv/mstk_ctrl.sv -----
// Controller of the Kruskal block: sequences load, sort, parent init, walk and output.
// Depends on mstk_pkg; drives mstk_datapath through cmd_t and reads sts_t.
module mstk_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           in_last,
  input  logic           out_ready,
  output logic           in_ready,
  output logic           out_valid,
  output logic           out_last,
  output mstk_pkg::cmd_t cmd,
  input  mstk_pkg::sts_t sts
);
  localparam logic [3:0] S_LOAD = 4'd0, S_SSTART = 4'd1, S_SREAD = 4'd2, S_SCMP = 4'd3,
                         S_SWR = 4'd4, S_PINIT = 4'd5, S_WREAD = 4'd6, S_WLOAD = 4'd7,
                         S_FSRC = 4'd8, S_FSRCW = 4'd9, S_FDST = 4'd10, S_FDSTW = 4'd11,
                         S_DEC = 4'd12, S_OUT = 4'd13, S_SLD = 4'd14;
  logic [3:0] state, state_next;
  logic       pend_last, pend_last_next;
  logic [6:0] hops, hops_next;

  assign in_ready = (state == S_LOAD);

  always_comb begin
    cmd = '0;
    state_next = state;
    pend_last_next = pend_last;
    hops_next = hops;
    unique case (state)
      S_LOAD: begin
        cmd.store_edge = in_fire;
        if (in_fire && in_last) state_next = S_SSTART;
      end
      S_SSTART: begin
        if (sts.sort_done) begin
          state_next = S_PINIT;
        end else begin
          cmd.sort_start = 1'b1; state_next = S_SREAD;
        end
      end
      S_SREAD: begin cmd.sort_step = 1'b1; state_next = S_SLD; end
      S_SLD: begin state_next = S_SCMP; end
      S_SCMP: begin cmd.sort_step = 1'b1; state_next = S_SWR; end
      S_SWR: begin
        cmd.sort_write = 1'b1;
        state_next = sts.sort_shift ? S_SLD : S_SSTART;
      end
      S_PINIT: begin
        cmd.par_init = 1'b1;
        if (sts.par_done) state_next = S_DEC;
      end
      S_DEC: begin
        if (sts.walk_done) begin
          state_next = S_OUT;
          pend_last_next = 1'b1;
          if (!sts.have_accept) cmd.emit_empty = 1'b1;
          cmd.finish = 1'b1;
        end else begin
          cmd.walk_read = 1'b1; state_next = S_WREAD;
        end
      end
      S_WREAD: state_next = S_WLOAD;
      S_WLOAD: begin
        if (sts.skip_edge) state_next = S_DEC;
        else begin hops_next = '0; state_next = S_FSRC; end
      end
      S_FSRC: begin cmd.find_src = 1'b0; state_next = S_FSRCW; end
      S_FSRCW: begin
        cmd.find_src = 1'b1;
        hops_next = hops + 7'd1;
        if (sts.src_at_root || hops == 7'(mstk_pkg::MaxVertices)) begin
          hops_next = '0; state_next = S_FDST;
        end else state_next = S_FSRC;
      end
      S_FDST: begin cmd.read_dst = 1'b1; state_next = S_FDSTW; end
      S_FDSTW: begin
        cmd.read_dst = 1'b1;
        cmd.find_dst = 1'b1;
        hops_next = hops + 7'd1;
        if (sts.dst_at_root || hops == 7'(mstk_pkg::MaxVertices)) begin
          if (sts.roots_differ) begin
            cmd.link = 1'b1; cmd.emit_edge = 1'b1;
            if (sts.have_accept) begin
              pend_last_next = 1'b0; state_next = S_OUT;
            end else state_next = S_DEC;
          end else state_next = S_DEC;
        end else state_next = S_FDST;
      end
      S_OUT: begin
        if (out_ready) begin
          if (pend_last) begin
            cmd.run_clear = 1'b1; cmd.walk_start = 1'b1; state_next = S_LOAD;
          end else state_next = S_DEC;
        end
      end
      default: state_next = S_LOAD;
    endcase
    if (state == S_SSTART && sts.sort_done) cmd.walk_start = 1'b1;
  end

  assign out_valid = (state == S_OUT);
  assign out_last = pend_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; pend_last <= 1'b0; hops <= '0;
    end else begin
      state <= state_next; pend_last <= pend_last_next; hops <= hops_next;
    end
  end
endmodule

// ----- sv/minimum_spanning_tree_kruskal.sv -----
// Top level of the Kruskal minimum spanning tree block.
// Edges arrive on s_axis one per cycle and are stored in a 256-entry memory;
// edges past 256 are dropped and flagged on the final result.
// The edge with tlast set starts a run: insertion sort by weight (stable),
// parent table initialization, then a union-find walk.
// Each accepted tree edge leaves on m_axis; tlast marks the final result.
// Latency is data dependent: the sort grows with each edge and each shift,
// and each walk step reads the edge and then steps node by node through
// each root search. An accepted edge is held until the next accept or the
// end of the walk, so it leaves only then, with its last flag known.
// s_axis accepts one edge per cycle while loading; it is held low during a run.
// A stalled m_axis holds the result and the walk.
// Reset empties the store and sets vertex_count to 64.
// Register 0 at address 0 of the APB port is vertex_count.
// Depends on mstk_pkg, mstk_ctrl, mstk_datapath.
module minimum_spanning_tree_kruskal (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // src_vertex, dst_vertex, edge_weight, zero fill
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // tree_src, tree_dst, tree_weight, zero fill
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser    // edge_valid, tree_complete, edges_dropped
);
  localparam logic [2:0] AddrVertexCount = 3'd0;
  logic [6:0] vertex_count;
  mstk_pkg::cmd_t  cmd;
  mstk_pkg::sts_t  sts;
  mstk_pkg::edge_t res_edge;
  logic res_valid, res_complete, res_dropped;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrVertexCount) ? {25'd0, vertex_count} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) vertex_count <= 7'd64;
    else if (psel && penable && pwrite && paddr == AddrVertexCount)
      vertex_count <= pwdata[6:0];
  end

  mstk_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(s_axis_tvalid && s_axis_tready),
    .in_last(s_axis_tlast),
    .out_ready(m_axis_tready),
    .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_last(m_axis_tlast),
    .cmd, .sts
  );

  mstk_datapath u_dp (
    .clk, .rst, .cmd, .sts,
    .in_edge({s_axis_tdata[5:0], s_axis_tdata[11:6], s_axis_tdata[27:12]}),
    .vertex_count, .res_edge, .res_valid, .res_complete, .res_dropped
  );

  assign m_axis_tdata = {4'd0, res_edge.weight, res_edge.dst, res_edge.src};
  assign m_axis_tuser = {res_dropped, res_complete, res_valid};
endmodule

// ----- sv/mstk_checker.sv -----
// Port-level checker for minimum_spanning_tree_kruskal, bound to the top level.
// Depends only on the top level's ports.
module mstk_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
    else $error("empty result carries data");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind minimum_spanning_tree_kruskal mstk_checker u_chk (
  .clk, .rst, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser, .pready
);

// ----- tb/tb.sv -----
// Self-checking testbench for minimum_spanning_tree_kruskal: streams graphs of edges,
// predicts the spanning tree edges with a Kruskal union-find model, checks m_axis.
// Depends on the RTL of the block.
`timescale 1ns / 100ps

module tb;
  typedef struct packed {
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [15:0] weight;
    logic        last;
  } edge_req_t;

  typedef struct packed {
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [15:0] weight;
    logic        valid;
    logic        last;
    logic        complete;
    logic        dropped;
  } tree_edge_t;

  localparam logic [2:0] VertexCountAddr = 3'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;

  minimum_spanning_tree_kruskal dut (.*);

  always #6 clk = ~clk;

  edge_req_t  pending_edges[$];
  tree_edge_t expected_tree[$];
  edge_req_t  graph_store[$];
  logic       graph_overflow = 1'b0;
  logic [6:0] vertex_reg = 7'd64;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatches = 0;
  logic       s_axis_tready_seen = 1'b0;
  edge_req_t  accepted;

  // Kruskal prediction for the graph held in graph_store
  task automatic predict_tree();
    edge_req_t  sorted[$];
    edge_req_t  key;
    logic [5:0] parent[64];
    int         nv, need, found, j, first_idx, rs, rd;
    tree_edge_t r;
    sorted = graph_store;
    for (int i = 1; i < sorted.size(); i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1].weight > key.weight) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    nv = (vertex_reg == 0) ? 1 : (vertex_reg > 64 ? 64 : int'(vertex_reg));
    need = nv - 1;
    for (int i = 0; i < 64; i++) parent[i] = 6'(i);
    found = 0;
    first_idx = expected_tree.size();
    for (int i = 0; i < sorted.size() && found < need; i++) begin
      if (sorted[i].src >= nv || sorted[i].dst >= nv) continue;
      rs = int'(sorted[i].src);
      while (int'(parent[rs]) != rs) rs = int'(parent[rs]);
      rd = int'(sorted[i].dst);
      while (int'(parent[rd]) != rd) rd = int'(parent[rd]);
      if (rs != rd) begin
        parent[rs] = 6'(rd);
        r = '0;
        r.src = sorted[i].src;
        r.dst = sorted[i].dst;
        r.weight = sorted[i].weight;
        r.valid = 1'b1;
        expected_tree.push_back(r);
        found++;
      end
    end
    if (found == 0) expected_tree.push_back(tree_edge_t'('0));
    j = expected_tree.size() - 1;
    expected_tree[j].last = 1'b1;
    expected_tree[j].complete = (found == need);
    expected_tree[j].dropped = graph_overflow;
    graph_store.delete();
    graph_overflow = 1'b0;
  endtask

  task automatic queue_edge(input int s, input int d, input int w, input bit last);
    edge_req_t e;
    e.src = 6'(s);
    e.dst = 6'(d);
    e.weight = 16'(w);
    e.last = last;
    pending_edges.push_back(e);
  endtask

  task automatic random_graph(input int nedges, input int vspan);
    for (int i = 0; i < nedges; i++)
      queue_edge($urandom_range(vspan - 1, 0), $urandom_range(vspan - 1, 0),
                 ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(40, 0),
                 i == nedges - 1);
  endtask

  task automatic wait_idle();
    while (pending_edges.size() != 0 || expected_tree.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [6:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= VertexCountAddr;
    pwdata <= {25'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    vertex_reg = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready_seen) begin
      if (pending_edges.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, pending_edges[0].weight, pending_edges[0].dst,
                         pending_edges[0].src};
        s_axis_tlast <= pending_edges[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    s_axis_tready_seen <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      accepted = pending_edges.pop_front();
      if (graph_store.size() < 256) graph_store.push_back(accepted);
      else graph_overflow = 1'b1;
      if (accepted.last) predict_tree();
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_tree.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result data=%h", m_axis_tdata);
      end else begin
        tree_edge_t x, got;
        x = expected_tree.pop_front();
        got = {m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tdata[27:12],
               m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1], m_axis_tuser[2]};
        if (got !== x) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected src=%0d dst=%0d w=%0d v=%b l=%b c=%b d=%b,",
                     x.src, x.dst, x.weight, x.valid, x.last, x.complete, x.dropped,
                     " got src=%0d dst=%0d w=%0d v=%b l=%b c=%b d=%b",
                     got.src, got.dst, got.weight, got.valid, got.last, got.complete,
                     got.dropped);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, empty tree, single vertex, out-of-range endpoints, ties
    queue_edge(0, 63, 16'hFFFF, 0);
    queue_edge(63, 0, 0, 0);
    queue_edge(5, 5, 7, 0);
    queue_edge(1, 2, 7, 0);
    queue_edge(2, 1, 7, 0);
    queue_edge(42, 21, 16'h5555, 1);
    queue_edge(3, 3, 1, 1);
    wait_idle();
    write_vertex_count(7'd1);
    queue_edge(0, 0, 9, 0);
    queue_edge(0, 1, 2, 1);
    wait_idle();
    write_vertex_count(7'd0);
    queue_edge(0, 0, 9, 1);
    wait_idle();
    write_vertex_count(7'd4);
    queue_edge(0, 1, 3, 0);
    queue_edge(1, 2, 3, 0);
    queue_edge(2, 0, 1, 0);
    queue_edge(4, 3, 0, 0);
    queue_edge(3, 2, 16'hFFFF, 1);
    queue_edge(0, 1, 5, 1);
    wait_idle();
    write_vertex_count(7'd127);
    // store overflow
    random_graph(258, 64);
    wait_idle();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 85 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 85 : 0;
      if (ph == 3) begin
        send_idle_pct = 15;
        recv_stall_pct = 15;
      end
      write_vertex_count(7'($urandom_range(5, 2)));
      for (int g = 0; g < 2; g++) random_graph($urandom_range(3, 1), vertex_reg + 1);
      wait_idle();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_tree.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
